// File: src/rlfw_pkg.sv
// Shared types and constants for the recursive lock with FIFO waiters.
package rlfw_pkg;

   localparam int THREAD_W = 4;
   localparam int NEST_W   = 8;
   localparam int SLOTS    = 16;
   localparam int SLOT_W   = 4;
   localparam int FILL_W   = 5;
   localparam int STATUS_W = 3;

   typedef enum logic {
      OP_ACQUIRE = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED         = 3'd0,
      ST_QUEUED          = 3'd1,
      ST_NEST_DEC        = 3'd2,
      ST_FREED           = 3'd3,
      ST_NOT_HOLDER      = 3'd4,
      ST_ALREADY_WAITING = 3'd5,
      ST_NEST_OVERFLOW   = 3'd6
   } status_type;

   typedef struct packed {
      logic                valid;
      op_type              operation;
      logic [THREAD_W-1:0] thread_id;
   } req_type;

   typedef struct packed {
      logic                push;
      logic                pop;
      logic [THREAD_W-1:0] push_id;
   } qcmd_type;

   typedef struct packed {
      logic [FILL_W-1:0]   fill;
      logic [THREAD_W-1:0] head_id;
      logic [SLOTS-1:0]    waiting;
   } qstat_type;

   typedef struct packed {
      status_type          status;
      logic                woken_valid;
      logic [THREAD_W-1:0] woken_thread;
      logic [NEST_W-1:0]   nest_count;
   } rsp_type;

endpackage

// File: src/recursive_lock_with_fifo_waiters.sv
// Top level of the recursive lock with a FIFO of waiting threads.
//
// Request channel: drive req_operation (0 acquire, 1 release) and
// req_thread_id with start high; the word is taken at the rising edge where
// start is high and busy is low. busy stays low, so a request may be issued
// in every cycle.
// Result channel: each request gives exactly one result word, shown for one
// cycle with rsp_valid high; it is taken at the edge that ends that cycle.
// The receiver cannot stall, so results are never held back.
// A taken request is captured in the request register, passes through the
// decision stage and is captured in the result register, which drives the
// outputs. Throughput: one request per cycle, set by that single decision
// stage, which also updates the holder and waiter state.
// Reset (synchronous, active high): frees the lock, empties the waiter FIFO
// and clears the waiting map; no result word is shown until a new request.
module recursive_lock_with_fifo_waiters import rlfw_pkg::*; #(
   parameter int MAX_THREADS = 16,
   parameter int MAX_NEST    = 255
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic [THREAD_W-1:0] req_thread_id,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_woken_valid,
   output logic [THREAD_W-1:0] rsp_woken_thread,
   output logic [NEST_W-1:0]   rsp_nest_count
);

   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff;
   qcmd_type  qcmd;
   qstat_type qstat;

   assign busy = 1'b0;

   always_comb begin
      req_in.valid     = start && !busy;
      req_in.operation = op_type'(req_operation);
      req_in.thread_id = req_thread_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_ff.valid <= req_in.valid;
         rsp_valid_ff <= req_ff.valid;
      end
      req_ff.operation <= req_in.operation;
      req_ff.thread_id <= req_in.thread_id;
      rsp_ff           <= rsp_in;
   end

   rlfw_lock #(
      .MAX_THREADS (MAX_THREADS),
      .MAX_NEST    (MAX_NEST)
   ) u_lock (
      .clock (clock),
      .reset (reset),
      .req   (req_ff),
      .qstat (qstat),
      .qcmd  (qcmd),
      .rsp   (rsp_in)
   );

   rlfw_wait_queue u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (qcmd),
      .stat  (qstat)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_woken_valid  = rsp_ff.woken_valid;
   assign rsp_woken_thread = rsp_ff.woken_thread;
   assign rsp_nest_count   = rsp_ff.nest_count;

endmodule

// File: src/rlfw_wait_queue.sv
// Waiter FIFO with its membership map.
module rlfw_wait_queue import rlfw_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qcmd_type  cmd,
   output qstat_type stat
);

   logic [THREAD_W-1:0] entry_ff [SLOTS];
   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [SLOT_W-1:0]   tail_ff, tail_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SLOTS-1:0]    waiting_ff, waiting_in;

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      waiting_in = waiting_ff;
      if (cmd.push) begin
         tail_in                  = tail_ff + 1'b1;
         fill_in                  = fill_ff + 1'b1;
         waiting_in[cmd.push_id]  = 1'b1;
      end else if (cmd.pop) begin
         head_in                        = head_ff + 1'b1;
         fill_in                        = fill_ff - 1'b1;
         waiting_in[entry_ff[head_ff]]  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         fill_ff    <= '0;
         waiting_ff <= '0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         fill_ff    <= fill_in;
         waiting_ff <= waiting_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         entry_ff[tail_ff] <= cmd.push_id;
      end
   end

   assign stat.fill    = fill_ff;
   assign stat.head_id = entry_ff[head_ff];
   assign stat.waiting = waiting_ff;

endmodule

// File: src/rlfw_lock.sv
// Holder state and per-request decision logic.
module rlfw_lock import rlfw_pkg::*; #(
   parameter int MAX_THREADS = 16,
   parameter int MAX_NEST    = 255
) (
   input  logic      clock,
   input  logic      reset,
   input  req_type   req,
   input  qstat_type qstat,
   output qcmd_type  qcmd,
   output rsp_type   rsp
);

   localparam int NEST_LIMIT = (MAX_NEST < 255) ? MAX_NEST : 255;
   localparam int FIFO_CAP   = (MAX_THREADS < SLOTS) ? MAX_THREADS : SLOTS;

   logic                holder_valid_ff, holder_valid_in;
   logic [THREAD_W-1:0] holder_thread_ff, holder_thread_in;
   logic [NEST_W-1:0]   depth_ff, depth_in;
   logic                tid_ok;
   logic                queue_full;
   logic                is_holder;

   assign tid_ok     = ({28'd0, req.thread_id} < 32'(MAX_THREADS));
   assign queue_full = (qstat.fill >= FILL_W'(FIFO_CAP));
   assign is_holder  = holder_valid_ff && (holder_thread_ff == req.thread_id);

   always_comb begin
      holder_valid_in  = holder_valid_ff;
      holder_thread_in = holder_thread_ff;
      depth_in         = depth_ff;
      qcmd.push        = 1'b0;
      qcmd.pop         = 1'b0;
      qcmd.push_id     = req.thread_id;
      rsp.status       = ST_NOT_HOLDER;
      rsp.woken_valid  = 1'b0;
      rsp.woken_thread = '0;
      if (req.valid && tid_ok) begin
         unique case (req.operation)
            OP_ACQUIRE: begin
               priority if (!holder_valid_ff) begin
                  holder_valid_in  = 1'b1;
                  holder_thread_in = req.thread_id;
                  depth_in         = NEST_W'(1);
                  rsp.status       = ST_GRANTED;
               end else if (is_holder) begin
                  if (depth_ff >= NEST_W'(NEST_LIMIT)) begin
                     rsp.status = ST_NEST_OVERFLOW;
                  end else begin
                     depth_in   = depth_ff + 1'b1;
                     rsp.status = ST_GRANTED;
                  end
               end else if (qstat.waiting[req.thread_id] || queue_full) begin
                  rsp.status = ST_ALREADY_WAITING;
               end else begin
                  qcmd.push  = 1'b1;
                  rsp.status = ST_QUEUED;
               end
            end
            OP_RELEASE: begin
               priority if (!is_holder) begin
                  rsp.status = ST_NOT_HOLDER;
               end else if (depth_ff > NEST_W'(1)) begin
                  depth_in   = depth_ff - 1'b1;
                  rsp.status = ST_NEST_DEC;
               end else begin
                  holder_valid_in  = 1'b0;
                  holder_thread_in = '0;
                  depth_in         = '0;
                  rsp.status       = ST_FREED;
                  if (qstat.fill != '0) begin
                     qcmd.pop         = 1'b1;
                     rsp.woken_valid  = 1'b1;
                     rsp.woken_thread = qstat.head_id;
                  end
               end
            end
            default: begin
               rsp.status = ST_NOT_HOLDER;
            end
         endcase
      end
      rsp.nest_count = depth_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holder_valid_ff  <= 1'b0;
         holder_thread_ff <= '0;
         depth_ff         <= '0;
      end else begin
         holder_valid_ff  <= holder_valid_in;
         holder_thread_ff <= holder_thread_in;
         depth_ff         <= depth_in;
      end
   end

endmodule

// File: src/rlfw_checker.sv
// Port-level checker for the recursive lock, bound to the top level.
module rlfw_checker import rlfw_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_woken_valid,
   input logic [THREAD_W-1:0] rsp_woken_thread,
   input logic [NEST_W-1:0]   rsp_nest_count
);

   a_word_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted word gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a request");

   a_woken_on_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_woken_valid) |-> (rsp_status == ST_FREED))
      else $error("waiter woken without freeing the lock");

   a_idle_woken_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_woken_valid) |-> (rsp_woken_thread == '0))
      else $error("woken thread set with no waiter popped");

   a_nest_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_status == ST_GRANTED) && (rsp_nest_count != '0))
                     || ((rsp_status == ST_FREED) && (rsp_nest_count == '0))
                     || ((rsp_status != ST_GRANTED) && (rsp_status != ST_FREED))))
      else $error("nesting count does not match status");

endmodule

bind recursive_lock_with_fifo_waiters rlfw_checker u_rlfw_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_woken_valid  (rsp_woken_valid),
   .rsp_woken_thread (rsp_woken_thread),
   .rsp_nest_count   (rsp_nest_count)
);

// File: verif/tb_top.sv
// Self-checking testbench for the recursive lock with a FIFO of waiting threads.
module tb_top;
   import rlfw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NEST_LIMIT   = 255;
   localparam int RANDOM_WORDS = 1300;
   localparam int DEEP_AT      = 500;
   localparam int QUIET_LIMIT  = 1000;

   typedef struct {
      op_type              op;
      logic [THREAD_W-1:0] tid;
      int                  gap;
   } req_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_operation = 1'b0;
   logic [THREAD_W-1:0] req_thread_id = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_woken_valid;
   logic [THREAD_W-1:0] rsp_woken_thread;
   logic [NEST_W-1:0]   rsp_nest_count;

   req_word_type requests_pending[$];
   rsp_type      outcomes_due[$];
   int           gap_left = 0;
   int           quiet_cycles = 0;
   int           errors = 0;
   bit           calm = 1'b0;

   logic                lock_held = 1'b0;
   logic [THREAD_W-1:0] lock_owner = '0;
   logic [NEST_W-1:0]   lock_depth = '0;
   logic [THREAD_W-1:0] waiter_line[$];
   logic [SLOTS-1:0]    waiter_map = '0;
   bit                  woken_ready = 1'b0;
   logic [THREAD_W-1:0] woken_id = '0;

   recursive_lock_with_fifo_waiters dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_thread_id    (req_thread_id),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_woken_valid  (rsp_woken_valid),
      .rsp_woken_thread (rsp_woken_thread),
      .rsp_nest_count   (rsp_nest_count)
   );

   always #1 clock = ~clock;

   function automatic rsp_type lock_outcome(op_type op, logic [THREAD_W-1:0] tid);
      rsp_type r;
      r = '0;
      r.status = ST_NOT_HOLDER;
      if (op == OP_ACQUIRE) begin
         if (!lock_held) begin
            lock_held  = 1'b1;
            lock_owner = tid;
            lock_depth = NEST_W'(1);
            r.status   = ST_GRANTED;
         end else if (lock_owner == tid) begin
            if (lock_depth >= NEST_LIMIT) begin
               r.status = ST_NEST_OVERFLOW;
            end else begin
               lock_depth = lock_depth + 1'b1;
               r.status   = ST_GRANTED;
            end
         end else if (waiter_map[tid] || waiter_line.size() >= SLOTS) begin
            r.status = ST_ALREADY_WAITING;
         end else begin
            waiter_line.push_back(tid);
            waiter_map[tid] = 1'b1;
            r.status = ST_QUEUED;
         end
      end else if (lock_held && lock_owner == tid) begin
         if (lock_depth > 1) begin
            lock_depth = lock_depth - 1'b1;
            r.status   = ST_NEST_DEC;
         end else begin
            lock_held  = 1'b0;
            lock_owner = '0;
            lock_depth = '0;
            r.status   = ST_FREED;
            if (waiter_line.size() > 0) begin
               r.woken_valid  = 1'b1;
               r.woken_thread = waiter_line.pop_front();
               waiter_map[r.woken_thread] = 1'b0;
               woken_id    = r.woken_thread;
               woken_ready = 1'b1;
            end
         end
      end
      r.nest_count = lock_depth;
      return r;
   endfunction

   task automatic queue_word(op_type op, logic [THREAD_W-1:0] tid);
      req_word_type w;
      w.op  = op;
      w.tid = tid;
      w.gap = calm ? 0 : $urandom_range(0, 15);
      requests_pending.push_back(w);
   endtask

   always @(posedge clock) begin : drive
      req_word_type w;
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else if (!start || !busy) begin
         if (gap_left != 0 || requests_pending.size() == 0) begin
            start <= 1'b0;
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
            end
         end else begin
            w = requests_pending.pop_front();
            start         <= 1'b1;
            req_operation <= w.op;
            req_thread_id <= w.tid;
            gap_left      <= w.gap;
         end
      end
   end

   always @(posedge clock) begin : observe
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (outcomes_due.size() == 0) begin
               $error("unexpected result word: status %0d", rsp_status);
               errors++;
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_woken_valid !== want.woken_valid) begin
                  $error("woken_valid: expected %0d, got %0d", want.woken_valid,
                         rsp_woken_valid);
                  errors++;
               end
               if (rsp_woken_thread !== want.woken_thread) begin
                  $error("woken_thread: expected %0d, got %0d", want.woken_thread,
                         rsp_woken_thread);
                  errors++;
               end
               if (rsp_nest_count !== want.nest_count) begin
                  $error("nest_count: expected %0d, got %0d", want.nest_count,
                         rsp_nest_count);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            outcomes_due.push_back(lock_outcome(op_type'(req_operation), req_thread_id));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int  sent;
      int  pick;
      int  overflow_hits;
      bit  deep_on;
      sent          = 0;
      overflow_hits = 0;
      deep_on       = 1'b0;

      queue_word(OP_ACQUIRE, 4'd0);
      queue_word(OP_ACQUIRE, 4'd0);
      queue_word(OP_ACQUIRE, 4'd15);
      queue_word(OP_ACQUIRE, 4'd1);
      queue_word(OP_ACQUIRE, 4'd15);
      queue_word(OP_RELEASE, 4'd3);
      queue_word(OP_RELEASE, 4'd0);
      queue_word(OP_RELEASE, 4'd0);
      queue_word(OP_ACQUIRE, 4'd1);
      queue_word(OP_RELEASE, 4'd1);
      queue_word(OP_RELEASE, 4'd1);
      queue_word(OP_ACQUIRE, 4'd15);
      queue_word(OP_ACQUIRE, 4'd10);
      queue_word(OP_ACQUIRE, 4'd5);
      queue_word(OP_RELEASE, 4'd15);
      queue_word(OP_RELEASE, 4'd5);
      queue_word(OP_ACQUIRE, 4'd10);
      queue_word(OP_RELEASE, 4'd10);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (sent < RANDOM_WORDS) begin
         @(negedge clock);
         if (requests_pending.size() == 0) begin
            if (sent % 64 == 0) begin
               calm = ($urandom_range(0, 3) == 0);
            end
            if (sent == DEEP_AT) begin
               deep_on = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (deep_on && overflow_hits < 4) begin
               if (!lock_held) begin
                  queue_word(OP_ACQUIRE, THREAD_W'($urandom_range(0, 15)));
               end else begin
                  if (lock_depth == NEST_LIMIT) begin
                     overflow_hits++;
                  end
                  queue_word(OP_ACQUIRE, lock_owner);
               end
            end else if (deep_on) begin
               if (lock_held) begin
                  queue_word(OP_RELEASE, lock_owner);
               end else begin
                  deep_on = 1'b0;
                  queue_word(OP_ACQUIRE, THREAD_W'($urandom_range(0, 15)));
               end
            end else if (pick < 30) begin
               if (lock_held) begin
                  queue_word(($urandom_range(0, 9) < 6) ? OP_RELEASE : OP_ACQUIRE, lock_owner);
               end else begin
                  queue_word(OP_ACQUIRE, THREAD_W'($urandom_range(0, 15)));
               end
            end else if (pick < 55 && woken_ready) begin
               woken_ready = 1'b0;
               queue_word(OP_ACQUIRE, woken_id);
            end else if (pick < 85) begin
               queue_word(OP_ACQUIRE, THREAD_W'($urandom_range(0, 15)));
            end else begin
               queue_word(OP_RELEASE, THREAD_W'($urandom_range(0, 15)));
            end
            sent++;
         end
      end

      @(negedge clock);
      while (requests_pending.size() != 0 || start || outcomes_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);

      if (errors == 0 && outcomes_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
